// ===== rtl/akdf_pkg.sv =====
// shared types, constants and arithmetic helpers for the altitude fusion filter
package akdf_pkg;

    // history depth of the delayed position buffer
    localparam int HIST_DEPTH = 32;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    // configuration register map
    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_TIME_STEP   = 3'd0;
    localparam logic [2:0] REG_POS_NOISE   = 3'd1;
    localparam logic [2:0] REG_VEL_NOISE   = 3'd2;
    localparam logic [2:0] REG_MEAS_NOISE  = 3'd3;
    localparam logic [2:0] REG_BIAS_GAIN   = 3'd4;

    // reset values of the registers and of the covariance
    localparam logic [23:0] DT_RESET        = 24'd83886;
    localparam logic [30:0] R0_RESET        = 31'd8389;
    localparam logic [30:0] R1_RESET        = 31'd10066;
    localparam logic [30:0] QN_RESET        = 31'd503316480;
    localparam logic [30:0] G_RESET         = 31'd8389;
    localparam logic signed [31:0] P_DIAG_RESET = 32'sd3019899;
    localparam logic signed [31:0] P_OFF_RESET  = 32'sd1677722;
    localparam logic signed [33:0] ONE_Q24      = 34'sd16777216;

    // saturation bounds at the internal wide width
    localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
    localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

    typedef struct packed {
        logic [23:0] dt;
        logic [30:0] r0;
        logic [30:0] r1;
        logic [30:0] qn;
        logic [30:0] g;
    } akdf_cfg_t;

    // operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_ACC_DT,
        MUL_VEL_DT,
        MUL_ADT_DT,
        MUL_P3_DT,
        MUL_P2_DT,
        MUL_C_DT,
        MUL_K0_Z,
        MUL_K1_Z,
        MUL_G_Z,
        MUL_OM_T0,
        MUL_OM_T1,
        MUL_K1_T0,
        MUL_K1_T1
    } akdf_mul_t;

    // register update taken from the product or the divider
    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_ADT,
        ACT_VDT,
        ACT_POS_PRED,
        ACT_C_T2,
        ACT_A,
        ACT_T0,
        ACT_SZ,
        ACT_K0,
        ACT_K1,
        ACT_POS_COR,
        ACT_VEL_COR,
        ACT_BIAS_COR,
        ACT_COV0,
        ACT_COV1,
        ACT_COV2,
        ACT_COV3
    } akdf_act_t;

    typedef struct packed {
        logic      load;
        akdf_mul_t mul;
        akdf_act_t act;
        logic      div_start;
        logic      div_sel;
        logic      finish;
    } akdf_cmd_t;

    typedef struct packed {
        logic div_done;
    } akdf_stat_t;

    typedef struct packed {
        logic              clip;
        logic signed [31:0] val;
    } akdf_sat_t;

    // clip to signed 32 bits and flag it
    function automatic akdf_sat_t sat32(input logic signed [71:0] x);
        akdf_sat_t r;
        if (x > SAT_MAX) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end
        else if (x < SAT_MIN) begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end
        else begin
            r.clip = 1'b0;
            r.val  = x[31:0];
        end
        return r;
    endfunction

    // rescale by 2^n, round half up
    function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] x,
                                                   input int unsigned n);
        logic signed [71:0] h;
        h = 72'sd1 <<< (n - 1);
        return (x + h) >>> n;
    endfunction

endpackage

// ===== rtl/akdf_if.sv =====
// item channels of the altitude fusion filter

// input item channel
interface akdf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_accel;
    logic signed [31:0] observed_altitude;
    logic [4:0]         delay_steps;

    modport source (output valid, drive_accel, observed_altitude, delay_steps, input ready);
    modport sink   (input valid, drive_accel, observed_altitude, delay_steps, output ready);
endinterface

// result item channel
interface akdf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_estimate;
    logic signed [31:0] velocity_estimate;
    logic signed [31:0] bias_estimate;
    logic signed [31:0] corrected_accel;
    logic               saturated;

    modport source (output valid, position_estimate, velocity_estimate, bias_estimate,
                    corrected_accel, saturated, input ready);
    modport sink   (input valid, position_estimate, velocity_estimate, bias_estimate,
                    corrected_accel, saturated, output ready);
endinterface

// ===== rtl/akdf_div.sv =====
// radix-2 restoring divider for the kalman gains, quotient capped at 32 bits
module akdf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [55:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic        over,
    output logic [31:0] quo
);

    logic        busy_reg;
    logic        done_reg;
    logic        over_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] sh_reg;
    logic [32:0] trial;
    logic        qbit;
    logic [32:0] trial_sub;

    // one quotient bit per cycle while busy
    always_comb
    begin
        trial     = {rem_reg, sh_reg[31]};
        qbit      = (trial >= {1'b0, den});
        trial_sub = trial - {1'b0, den};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            if (start) begin
                cnt_reg <= '0;
                if ({8'd0, num[55:32]} >= den) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else begin
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                end
            end
            else if (busy_reg) begin
                cnt_reg  <= cnt_reg + 5'd1;
                busy_reg <= (cnt_reg != 5'd31);
                done_reg <= (cnt_reg == 5'd31);
            end
            else begin
                done_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start) begin
            over_reg <= ({8'd0, num[55:32]} >= den);
            rem_reg  <= {8'd0, num[55:32]};
            sh_reg   <= num[31:0];
        end
        else if (busy_reg) begin
            rem_reg <= qbit ? trial_sub[31:0] : trial[31:0];
            sh_reg  <= {sh_reg[30:0], qbit};
        end
    end

    assign done = done_reg;
    assign over = over_reg;
    assign quo  = sh_reg;

endmodule

// ===== rtl/akdf_ctrl.sv =====
// sequencer for the filter steps and the result handshake
module akdf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  akdf_pkg::akdf_stat_t stat,
    output akdf_pkg::akdf_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8,
        S_D0_GO, S_D0_WAIT, S_D1_GO, S_D1_WAIT,
        S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // command decode and next state
    always_comb
    begin
        cmd           = '0;
        cmd.mul       = akdf_pkg::MUL_ACC_DT;
        cmd.act       = akdf_pkg::ACT_NONE;
        state_next    = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_C1;
                end
            end
            S_C1: begin
                cmd.mul    = akdf_pkg::MUL_ACC_DT;
                state_next = S_C2;
            end
            S_C2: begin
                cmd.act    = akdf_pkg::ACT_ADT;
                cmd.mul    = akdf_pkg::MUL_VEL_DT;
                state_next = S_C3;
            end
            S_C3: begin
                cmd.act    = akdf_pkg::ACT_VDT;
                cmd.mul    = akdf_pkg::MUL_ADT_DT;
                state_next = S_C4;
            end
            S_C4: begin
                cmd.act    = akdf_pkg::ACT_POS_PRED;
                cmd.mul    = akdf_pkg::MUL_P3_DT;
                state_next = S_C5;
            end
            S_C5: begin
                cmd.act    = akdf_pkg::ACT_C_T2;
                cmd.mul    = akdf_pkg::MUL_P2_DT;
                state_next = S_C6;
            end
            S_C6: begin
                cmd.act    = akdf_pkg::ACT_A;
                cmd.mul    = akdf_pkg::MUL_C_DT;
                state_next = S_C7;
            end
            S_C7: begin
                cmd.act    = akdf_pkg::ACT_T0;
                state_next = S_C8;
            end
            S_C8: begin
                cmd.act    = akdf_pkg::ACT_SZ;
                state_next = S_D0_GO;
            end
            S_D0_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_D0_WAIT;
            end
            S_D0_WAIT: begin
                if (stat.div_done) begin
                    cmd.act    = akdf_pkg::ACT_K0;
                    state_next = S_D1_GO;
                end
            end
            S_D1_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_D1_WAIT;
            end
            S_D1_WAIT: begin
                cmd.div_sel = 1'b1;
                if (stat.div_done) begin
                    cmd.act    = akdf_pkg::ACT_K1;
                    state_next = S_E1;
                end
            end
            S_E1: begin
                cmd.mul    = akdf_pkg::MUL_K0_Z;
                state_next = S_E2;
            end
            S_E2: begin
                cmd.act    = akdf_pkg::ACT_POS_COR;
                cmd.mul    = akdf_pkg::MUL_K1_Z;
                state_next = S_E3;
            end
            S_E3: begin
                cmd.act    = akdf_pkg::ACT_VEL_COR;
                cmd.mul    = akdf_pkg::MUL_G_Z;
                state_next = S_E4;
            end
            S_E4: begin
                cmd.act    = akdf_pkg::ACT_BIAS_COR;
                cmd.mul    = akdf_pkg::MUL_OM_T0;
                state_next = S_E5;
            end
            S_E5: begin
                cmd.act    = akdf_pkg::ACT_COV0;
                cmd.mul    = akdf_pkg::MUL_OM_T1;
                state_next = S_E6;
            end
            S_E6: begin
                cmd.act    = akdf_pkg::ACT_COV1;
                cmd.mul    = akdf_pkg::MUL_K1_T0;
                state_next = S_E7;
            end
            S_E7: begin
                cmd.act    = akdf_pkg::ACT_COV2;
                cmd.mul    = akdf_pkg::MUL_K1_T1;
                state_next = S_E8;
            end
            S_E8: begin
                cmd.act    = akdf_pkg::ACT_COV3;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/akdf_dp.sv =====
// filter datapath: state, shared multiplier, gain divider and position history
module akdf_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  akdf_pkg::akdf_cfg_t  cfg,
    input  akdf_pkg::akdf_cmd_t  cmd,
    output akdf_pkg::akdf_stat_t stat,
    input  logic signed [31:0]  drive_accel,
    input  logic signed [31:0]  observed_altitude,
    input  logic [4:0]          delay_steps,
    output logic signed [31:0]  position_estimate,
    output logic signed [31:0]  velocity_estimate,
    output logic signed [31:0]  bias_estimate,
    output logic signed [31:0]  corrected_accel,
    output logic                saturated
);

    localparam int AW = akdf_pkg::HIST_AW;
    localparam int D  = akdf_pkg::HIST_DEPTH;

    // filter state
    logic signed [31:0] pos_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] bias_reg;
    logic signed [31:0] cov_reg [4];

    // per item working registers
    logic signed [31:0] accel_reg;
    logic signed [31:0] obs_reg;
    logic [AW-1:0]      idx_reg;
    logic signed [32:0] adt_reg;
    logic signed [67:0] vdt_reg;
    logic signed [43:0] a_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] t0_reg;
    logic signed [31:0] t2_reg;
    logic signed [31:0] t3_reg;
    logic signed [32:0] s_reg;
    logic               spos_reg;
    logic signed [31:0] k0_reg;
    logic signed [31:0] k1_reg;
    logic signed [31:0] z_reg;
    logic               clip_reg;
    logic signed [67:0] prod_reg;

    // history store
    logic signed [31:0] hist_mem [D];
    logic [D-1:0]       hvalid_reg;
    logic [AW-1:0]      head_reg;
    logic signed [31:0] hist_q;
    logic               hv_q;
    logic [AW:0]        rd_sum;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      head_new;
    logic [AW-1:0]      idx_in;

    // combinational helpers
    logic signed [33:0] op_a;
    logic signed [33:0] op_b;
    logic signed [33:0] om;
    logic signed [71:0] prod_x;
    logic signed [71:0] r24;
    logic signed [31:0] hist_val;
    logic signed [32:0] s_next;
    akdf_pkg::akdf_sat_t sat_acc, sat_pp, sat_vp, sat_c, sat_t2, sat_t3, sat_t0, sat_z;
    akdf_pkg::akdf_sat_t sat_pc, sat_vc, sat_bc, sat_c01, sat_c2, sat_c3;

    // divider hookup and gain shaping
    logic               div_done;
    logic               div_over;
    logic [31:0]        div_quo;
    logic               gneg;
    logic signed [31:0] gsrc;
    logic [31:0]        gmag;
    logic [55:0]        div_num;
    logic [31:0]        qc;
    logic signed [31:0] gain;
    logic               gclip;

    // history address arithmetic
    always_comb
    begin
        idx_in   = (int'(delay_steps) >= D) ? AW'(D - 1) : AW'(delay_steps);
        rd_sum   = {1'b0, head_reg} + {1'b0, idx_reg};
        rd_addr  = (rd_sum >= (AW+1)'(D)) ? AW'(rd_sum - (AW+1)'(D)) : rd_sum[AW-1:0];
        head_new = (head_reg == '0) ? AW'(D - 1) : head_reg - AW'(1);
    end

    // multiplier operand select
    always_comb
    begin
        om   = akdf_pkg::ONE_Q24 - 34'(k0_reg);
        op_a = 34'(accel_reg);
        op_b = {10'd0, cfg.dt};
        case (cmd.mul)
            akdf_pkg::MUL_ACC_DT: begin
                op_a = 34'(accel_reg);
                op_b = {10'd0, cfg.dt};
            end
            akdf_pkg::MUL_VEL_DT: begin
                op_a = 34'(vel_reg);
                op_b = {10'd0, cfg.dt};
            end
            akdf_pkg::MUL_ADT_DT: begin
                op_a = 34'(adt_reg);
                op_b = {10'd0, cfg.dt};
            end
            akdf_pkg::MUL_P3_DT: begin
                op_a = 34'(cov_reg[3]);
                op_b = {10'd0, cfg.dt};
            end
            akdf_pkg::MUL_P2_DT: begin
                op_a = 34'(cov_reg[2]);
                op_b = {10'd0, cfg.dt};
            end
            akdf_pkg::MUL_C_DT: begin
                op_a = 34'(c_reg);
                op_b = {10'd0, cfg.dt};
            end
            akdf_pkg::MUL_K0_Z: begin
                op_a = 34'(k0_reg);
                op_b = 34'(z_reg);
            end
            akdf_pkg::MUL_K1_Z: begin
                op_a = 34'(k1_reg);
                op_b = 34'(z_reg);
            end
            akdf_pkg::MUL_G_Z: begin
                op_a = {3'd0, cfg.g};
                op_b = 34'(z_reg);
            end
            akdf_pkg::MUL_OM_T0: begin
                op_a = om;
                op_b = 34'(t0_reg);
            end
            akdf_pkg::MUL_OM_T1: begin
                op_a = om;
                op_b = 34'(c_reg);
            end
            akdf_pkg::MUL_K1_T0: begin
                op_a = 34'(k1_reg);
                op_b = 34'(t0_reg);
            end
            akdf_pkg::MUL_K1_T1: begin
                op_a = 34'(k1_reg);
                op_b = 34'(c_reg);
            end
            default: begin
                op_a = 34'(accel_reg);
                op_b = {10'd0, cfg.dt};
            end
        endcase
    end

    // candidate updates from the registered product
    always_comb
    begin
        prod_x   = 72'(prod_reg);
        r24      = akdf_pkg::rnd_shr(prod_x, 24);
        hist_val = hv_q ? hist_q : 32'sd0;
        sat_acc  = akdf_pkg::sat32(72'(drive_accel) + 72'(bias_reg));
        sat_pp   = akdf_pkg::sat32(72'(pos_reg)
                   + akdf_pkg::rnd_shr((72'(vdt_reg) <<< 1) + prod_x, 25));
        sat_vp   = akdf_pkg::sat32(72'(vel_reg) + 72'(adt_reg));
        sat_c    = akdf_pkg::sat32(72'(cov_reg[1]) + r24);
        sat_t2   = akdf_pkg::sat32(72'(cov_reg[2]) + r24);
        sat_t3   = akdf_pkg::sat32(72'(cov_reg[3]) + $signed({41'd0, cfg.r1}));
        sat_t0   = akdf_pkg::sat32(72'(cov_reg[0]) + 72'(a_reg) + r24
                   + $signed({41'd0, cfg.r0}));
        s_next   = 33'(t0_reg) + $signed({2'd0, cfg.qn});
        sat_z    = akdf_pkg::sat32(72'(obs_reg) - 72'(hist_val));
        sat_pc   = akdf_pkg::sat32(72'(pos_reg) + r24);
        sat_vc   = akdf_pkg::sat32(72'(vel_reg) + r24);
        sat_bc   = akdf_pkg::sat32(72'(bias_reg) + r24);
        sat_c01  = akdf_pkg::sat32(r24);
        sat_c2   = akdf_pkg::sat32(72'(t2_reg) - r24);
        sat_c3   = akdf_pkg::sat32(72'(t3_reg) - r24);
    end

    // gain numerator and result shaping
    always_comb
    begin
        gsrc    = cmd.div_sel ? t2_reg : t0_reg;
        gneg    = gsrc[31];
        gmag    = gneg ? 32'(-gsrc) : 32'(gsrc);
        div_num = {gmag, 24'd0} + 56'(s_reg[31:1]);
        qc      = (div_over || div_quo > 32'h80000000) ? 32'h80000000 : div_quo;
        gclip   = 1'b0;
        if (!spos_reg) begin
            gain = 32'sd0;
        end
        else if (gneg) begin
            gain = $signed(32'(-qc));
        end
        else if (qc == 32'h80000000) begin
            gain  = 32'sh7FFFFFFF;
            gclip = 1'b1;
        end
        else begin
            gain = $signed(qc);
        end
    end

    akdf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (s_reg[31:0]),
        .done  (div_done),
        .over  (div_over),
        .quo   (div_quo)
    );

    assign stat.div_done = div_done;

    // filter state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg    <= '0;
            vel_reg    <= '0;
            bias_reg   <= '0;
            cov_reg[0] <= akdf_pkg::P_DIAG_RESET;
            cov_reg[1] <= akdf_pkg::P_OFF_RESET;
            cov_reg[2] <= akdf_pkg::P_OFF_RESET;
            cov_reg[3] <= akdf_pkg::P_DIAG_RESET;
            head_reg   <= '0;
            hvalid_reg <= '0;
        end
        else begin
            case (cmd.act)
                akdf_pkg::ACT_POS_PRED: begin
                    pos_reg <= sat_pp.val;
                    vel_reg <= sat_vp.val;
                end
                akdf_pkg::ACT_POS_COR:  pos_reg    <= sat_pc.val;
                akdf_pkg::ACT_VEL_COR:  vel_reg    <= sat_vc.val;
                akdf_pkg::ACT_BIAS_COR: bias_reg   <= sat_bc.val;
                akdf_pkg::ACT_COV0:     cov_reg[0] <= sat_c01.val;
                akdf_pkg::ACT_COV1:     cov_reg[1] <= sat_c01.val;
                akdf_pkg::ACT_COV2:     cov_reg[2] <= sat_c2.val;
                akdf_pkg::ACT_COV3:     cov_reg[3] <= sat_c3.val;
                default: begin
                end
            endcase
            if (cmd.finish) begin
                head_reg             <= head_new;
                hvalid_reg[head_new] <= 1'b1;
            end
        end
    end

    // working registers, product and clip flag
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (cmd.load) begin
            accel_reg <= sat_acc.val;
            clip_reg  <= sat_acc.clip;
            obs_reg   <= observed_altitude;
            idx_reg   <= idx_in;
        end
        case (cmd.act)
            akdf_pkg::ACT_ADT: adt_reg <= 33'(r24);
            akdf_pkg::ACT_VDT: vdt_reg <= prod_reg;
            akdf_pkg::ACT_POS_PRED: clip_reg <= clip_reg | sat_pp.clip | sat_vp.clip;
            akdf_pkg::ACT_C_T2: begin
                c_reg    <= sat_c.val;
                t2_reg   <= sat_t2.val;
                t3_reg   <= sat_t3.val;
                clip_reg <= clip_reg | sat_c.clip | sat_t2.clip | sat_t3.clip;
            end
            akdf_pkg::ACT_A: a_reg <= 44'(r24);
            akdf_pkg::ACT_T0: begin
                t0_reg   <= sat_t0.val;
                clip_reg <= clip_reg | sat_t0.clip;
            end
            akdf_pkg::ACT_SZ: begin
                s_reg    <= s_next;
                spos_reg <= !s_next[32] && (s_next != '0);
                z_reg    <= sat_z.val;
                clip_reg <= clip_reg | sat_z.clip;
            end
            akdf_pkg::ACT_K0: begin
                k0_reg   <= gain;
                clip_reg <= clip_reg | gclip;
            end
            akdf_pkg::ACT_K1: begin
                k1_reg   <= gain;
                clip_reg <= clip_reg | gclip;
            end
            akdf_pkg::ACT_POS_COR:  clip_reg <= clip_reg | sat_pc.clip;
            akdf_pkg::ACT_VEL_COR:  clip_reg <= clip_reg | sat_vc.clip;
            akdf_pkg::ACT_BIAS_COR: clip_reg <= clip_reg | sat_bc.clip;
            akdf_pkg::ACT_COV0:     clip_reg <= clip_reg | sat_c01.clip;
            akdf_pkg::ACT_COV1:     clip_reg <= clip_reg | sat_c01.clip;
            akdf_pkg::ACT_COV2:     clip_reg <= clip_reg | sat_c2.clip;
            akdf_pkg::ACT_COV3:     clip_reg <= clip_reg | sat_c3.clip;
            default: begin
            end
        endcase
    end

    // history memory, registered read
    always_ff @(posedge clk)
    begin
        hist_q <= hist_mem[rd_addr];
        hv_q   <= hvalid_reg[rd_addr];
        if (cmd.finish) begin
            hist_mem[head_new] <= pos_reg;
        end
    end

    // result item register
    always_ff @(posedge clk)
    begin
        if (cmd.finish) begin
            position_estimate <= pos_reg;
            velocity_estimate <= vel_reg;
            bias_estimate     <= bias_reg;
            corrected_accel   <= accel_reg;
            saturated         <= clip_reg;
        end
    end

endmodule

// ===== rtl/altitude_kalman_delayed_fusion.sv =====
// top level of the altitude kalman filter with delayed observation fusion
//
//  channel  dir  handshake        payload
//  in_ch    in   valid / ready    drive_accel, observed_altitude, delay_steps
//  out_ch   out  valid / ready    position_estimate, velocity_estimate,
//                                 bias_estimate, corrected_accel, saturated
//  apb      in   psel / penable   paddr, pwdata, prdata (five registers)
//
//  one item at a time; the two gain divisions run on the shared radix-2
//  divider, the rest is one shared 34x34 multiplier step per cycle
//  asynchronous active-low reset restores configuration registers, state and history
//  the next item is accepted while a result waits in the output register
module altitude_kalman_delayed_fusion (
    input  logic                         clk,
    input  logic                         rst_n,
    akdf_in_if.sink                      in_ch,
    akdf_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [akdf_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    akdf_pkg::akdf_cfg_t  cfg_reg;
    akdf_pkg::akdf_cmd_t  cmd;
    akdf_pkg::akdf_stat_t stat;
    logic                 wr_en;
    logic [2:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.dt <= akdf_pkg::DT_RESET;
            cfg_reg.r0 <= akdf_pkg::R0_RESET;
            cfg_reg.r1 <= akdf_pkg::R1_RESET;
            cfg_reg.qn <= akdf_pkg::QN_RESET;
            cfg_reg.g  <= akdf_pkg::G_RESET;
        end
        else if (wr_en) begin
            unique case (reg_idx)
                akdf_pkg::REG_TIME_STEP:  cfg_reg.dt <= pwdata[23:0];
                akdf_pkg::REG_POS_NOISE:  cfg_reg.r0 <= pwdata[30:0];
                akdf_pkg::REG_VEL_NOISE:  cfg_reg.r1 <= pwdata[30:0];
                akdf_pkg::REG_MEAS_NOISE: cfg_reg.qn <= pwdata[30:0];
                akdf_pkg::REG_BIAS_GAIN:  cfg_reg.g  <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            akdf_pkg::REG_TIME_STEP:  prdata = {8'd0, cfg_reg.dt};
            akdf_pkg::REG_POS_NOISE:  prdata = {1'b0, cfg_reg.r0};
            akdf_pkg::REG_VEL_NOISE:  prdata = {1'b0, cfg_reg.r1};
            akdf_pkg::REG_MEAS_NOISE: prdata = {1'b0, cfg_reg.qn};
            akdf_pkg::REG_BIAS_GAIN:  prdata = {1'b0, cfg_reg.g};
            default:                  prdata = '0;
        endcase
    end

    akdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    akdf_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .cmd               (cmd),
        .stat              (stat),
        .drive_accel       (in_ch.drive_accel),
        .observed_altitude (in_ch.observed_altitude),
        .delay_steps       (in_ch.delay_steps),
        .position_estimate (out_ch.position_estimate),
        .velocity_estimate (out_ch.velocity_estimate),
        .bias_estimate     (out_ch.bias_estimate),
        .corrected_accel   (out_ch.corrected_accel),
        .saturated         (out_ch.saturated)
    );

endmodule
